FILE: rtl/nsf_pkg.sv
package nsf_pkg;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CK0     = 2'd2,
    PH_CK1     = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_BAD_HEX  = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    TY_GSA     = 3'd0,
    TY_GGA     = 3'd1,
    TY_RMC     = 3'd2,
    TY_ZDA     = 3'd3,
    TY_UNKNOWN = 3'd4
  } sentence_type_t;

  localparam logic [7:0] CHAR_START = 8'h24;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam int unsigned HEADER_LEN = 5;

  // Header strings with the first character in the lowest byte.
  localparam logic [HEADER_LEN-1:0][7:0] NAME_GSA = "ASGPG";
  localparam logic [HEADER_LEN-1:0][7:0] NAME_GGA = "AGGPG";
  localparam logic [HEADER_LEN-1:0][7:0] NAME_RMC = "CMRPG";
  localparam logic [HEADER_LEN-1:0][7:0] NAME_ZDA = "ADZPG";

  typedef struct packed {
    logic       bad;
    logic [3:0] value;
  } hex_digit_t;

  typedef struct packed {
    logic [7:0]     computed_checksum;
    logic [7:0]     received_checksum;
    logic [7:0]     payload_length;
    sentence_type_t sentence_type;
    status_t        status;
  } nsf_result_t;

  localparam int unsigned RESULT_BITS = $bits(nsf_result_t);
  localparam int unsigned TDATA_BITS  = ((RESULT_BITS + 7) / 8) * 8;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    logic [7:0] diff;
    d.bad = 1'b0;
    d.value = 4'd0;
    diff = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      diff = c - 8'h30;
      d.value = diff[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      diff = c - 8'h37;
      d.value = diff[3:0];
    end else if (c >= 8'h61 && c <= 8'h66) begin
      diff = c - 8'h57;
      d.value = diff[3:0];
    end else begin
      d.bad = 1'b1;
    end
    return d;
  endfunction

endpackage

FILE: rtl/nsf_tracker.sv
module nsf_tracker import nsf_pkg::*; #(
  parameter int MAX_LEN = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [7:0]  in_byte,
  output logic        last_digit,
  output logic        res_valid,
  output nsf_result_t res
);

  localparam logic [7:0] MaxLen = 8'(MAX_LEN);

  phase_t                      phase, phase_next;
  logic [7:0]                  running_xor, running_xor_next;
  logic [7:0]                  byte_count, byte_count_next;
  logic [HEADER_LEN-1:0][7:0]  header_chars, header_chars_next;
  logic [3:0]                  high_nibble, high_nibble_next;
  logic                        hex_error, hex_error_next;
  logic                        overflow_flag, overflow_flag_next;
  hex_digit_t                  digit;
  logic [7:0]                  rx_sum;
  sentence_type_t              kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      running_xor   <= 8'd0;
      byte_count    <= 8'd0;
      header_chars  <= '0;
      high_nibble   <= 4'd0;
      hex_error     <= 1'b0;
      overflow_flag <= 1'b0;
    end else begin
      phase         <= phase_next;
      running_xor   <= running_xor_next;
      byte_count    <= byte_count_next;
      header_chars  <= header_chars_next;
      high_nibble   <= high_nibble_next;
      hex_error     <= hex_error_next;
      overflow_flag <= overflow_flag_next;
    end
  end

  always_comb begin
    digit  = hex_decode(in_byte);
    rx_sum = {high_nibble, digit.value};
  end

  always_comb begin
    if (byte_count < 8'(HEADER_LEN)) begin
      kind = TY_UNKNOWN;
    end else if (header_chars == NAME_GSA) begin
      kind = TY_GSA;
    end else if (header_chars == NAME_GGA) begin
      kind = TY_GGA;
    end else if (header_chars == NAME_RMC) begin
      kind = TY_RMC;
    end else if (header_chars == NAME_ZDA) begin
      kind = TY_ZDA;
    end else begin
      kind = TY_UNKNOWN;
    end
  end

  always_comb begin
    phase_next         = phase;
    running_xor_next   = running_xor;
    byte_count_next    = byte_count;
    header_chars_next  = header_chars;
    high_nibble_next   = high_nibble;
    hex_error_next     = hex_error;
    overflow_flag_next = overflow_flag;
    res_valid          = 1'b0;

    res.computed_checksum = running_xor;
    res.received_checksum = rx_sum;
    res.payload_length    = byte_count;
    res.sentence_type     = kind;
    if (overflow_flag) begin
      res.status = ST_TOO_LONG;
    end else if (hex_error || digit.bad) begin
      res.status = ST_BAD_HEX;
    end else if (rx_sum != running_xor) begin
      res.status = ST_MISMATCH;
    end else begin
      res.status = ST_OK;
    end

    if (in_valid) begin
      unique case (phase)
        PH_HUNT: begin
          if (in_byte == CHAR_START) begin
            running_xor_next   = 8'd0;
            byte_count_next    = 8'd0;
            header_chars_next  = '0;
            high_nibble_next   = 4'd0;
            hex_error_next     = 1'b0;
            overflow_flag_next = 1'b0;
            phase_next         = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (in_byte == CHAR_STAR) begin
            phase_next = PH_CK0;
          end else begin
            running_xor_next = running_xor ^ in_byte;
            if (byte_count < 8'(HEADER_LEN)) begin
              header_chars_next[byte_count[2:0]] = in_byte;
            end
            if (byte_count < MaxLen) begin
              byte_count_next = byte_count + 8'd1;
            end else begin
              overflow_flag_next = 1'b1;
            end
          end
        end
        PH_CK0: begin
          high_nibble_next = digit.value;
          if (digit.bad) begin
            hex_error_next = 1'b1;
          end
          phase_next = PH_CK1;
        end
        PH_CK1: begin
          res_valid  = 1'b1;
          phase_next = PH_HUNT;
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  assign last_digit = (phase == PH_CK1);

  assert property (@(posedge clk) disable iff (rst) byte_count <= MaxLen)
    else $error("Payload count has run past the length limit.");

  assert property (@(posedge clk) disable iff (rst) overflow_flag |-> byte_count == MaxLen)
    else $error("Overflow is flagged below the length limit.");

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && phase == PH_HUNT && in_byte == CHAR_START)
      |=> (phase == PH_PAYLOAD && byte_count == 8'd0 && !overflow_flag && !hex_error))
    else $error("A start character has not opened a clean sentence.");

endmodule

FILE: rtl/nsf_out_stage.sv
module nsf_out_stage import nsf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  nsf_result_t           res,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_BITS-1:0] m_tdata
);

  logic        m_tvalid_next;
  nsf_result_t held;

  assign m_tvalid_next = load || (m_tvalid && !m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_tdata = TDATA_BITS'(held);

  assert property (@(posedge clk) disable iff (rst) load |-> (!m_tvalid || m_tready))
    else $error("A new result has overwritten one still waiting.");

endmodule

FILE: rtl/nmea_sentence_framer_core.sv
// Channel  Direction  tdata fields, lowest bit first               Transaction
// s_axis   in         rx_byte[7:0]                                 one received byte
// m_axis   out        status[1:0], sentence_type[4:2],             one checked sentence
//                     payload_length[12:5], received_checksum[20:13],
//                     computed_checksum[28:21], zero fill[31:29]
//
// A byte is taken whenever s_tvalid and s_tready are both high; a sentence
// result is registered in the cycle after its second checksum byte is accepted.
// Reset returns the framer to hunting for a start character with no result held.
// Input is stalled only when a sentence's final byte arrives while the previous
// result is still waiting and the output is not ready.
module nmea_sentence_framer_core import nsf_pkg::*; #(
  parameter int MAX_LEN = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // rx_byte[7:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_BITS-1:0] m_tdata    // status, sentence_type, payload_length,
                                           // received_checksum, computed_checksum
);

  logic        accept;
  logic        last_digit;
  logic        res_valid;
  nsf_result_t res;

  assign s_tready = !last_digit || !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  nsf_tracker #(
    .MAX_LEN(MAX_LEN)
  ) u_tracker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_byte   (s_tdata),
    .last_digit(last_digit),
    .res_valid (res_valid),
    .res       (res)
  );

  nsf_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (res_valid),
    .res     (res),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

endmodule
